@@ hw/rtl/ostp_pkg.sv @@
// Package for the one-shot timer pool: sizes, opcode/result codes, sequencer states.
// No dependencies; every other file of the block depends on it.
package ostp_pkg;

  localparam int NUM_SLOTS = 3;
  localparam int TIME_W    = 48;
  localparam int MAX_OUT   = 3;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_OUT + 1);
  localparam int SLOT_W    = 2;
  localparam int VAL_W     = 32;
  localparam int CB_W      = 2;
  localparam int DUR_W     = 32;

  // Tick increments in 1/1024 us: 16.66 ms / 256 and 20 ms / 256.
  localparam logic [TIME_W-1:0] INC_NTSC = TIME_W'(66640);
  localparam logic [TIME_W-1:0] INC_PAL  = TIME_W'(80000);

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_INSERT   = 2'd1,
    OP_DELETE   = 2'd2,
    OP_FREE_ALL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_INSERTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_DONE     = 2'd2,
    KIND_FIRED    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_SCAN,
    ST_FIRE,
    ST_INSERT,
    ST_REPLY
  } state_t;

endpackage

@@ hw/rtl/ostp_if.sv @@
// Valid/ready channel interfaces for the timer pool request and result streams.
// Depends on ostp_pkg for field widths and codes.
interface ostp_req_if;
  logic                               valid;
  logic                               ready;
  ostp_pkg::op_t                      opcode;
  logic [ostp_pkg::DUR_W-1:0]         duration;
  logic signed [ostp_pkg::VAL_W-1:0]  param;
  logic [ostp_pkg::CB_W-1:0]          callback_id;
  logic [ostp_pkg::SLOT_W-1:0]        slot;

  modport source (output valid, opcode, duration, param, callback_id, slot, input ready);
  modport sink   (input valid, opcode, duration, param, callback_id, slot, output ready);
endinterface

interface ostp_rsp_if;
  logic                               valid;
  logic                               ready;
  ostp_pkg::kind_t                    kind;
  logic [ostp_pkg::SLOT_W-1:0]        slot_out;
  logic signed [ostp_pkg::VAL_W-1:0]  param_out;
  logic [ostp_pkg::CB_W-1:0]          callback_out;
  logic [ostp_pkg::TIME_W-1:0]        current_time;
  logic                               last;

  modport source (output valid, kind, slot_out, param_out, callback_out, current_time, last,
                  input ready);
  modport sink   (input valid, kind, slot_out, param_out, callback_out, current_time, last,
                  output ready);
endinterface

@@ hw/rtl/one_shot_timer_pool.sv @@
// Top level of the one-shot timer pool: sequencer, slot registers, shared adder.
// Depends on ostp_pkg and the channel interfaces in ostp_if.sv.
//
// Usage:
//   in_chan carries one request per valid/ready handshake: tick, insert,
//   delete slot or free all. out_chan returns one to MAX_OUT results per
//   request; the final one has last set. cfg_we/cfg_wdata load the frame
//   select bit (tick increment 80000 when set, 66640 when clear); write it
//   only while the block is idle.
//   One request is in flight at a time and in_chan.ready is low meanwhile.
//   All time arithmetic goes through one shared 49-bit adder, one operation
//   per cycle, so a request runs through these steps:
//     tick        : accept, advance, one compare per slot
//                   plus one step per result
//     insert      : accept, deadline add, reply
//     delete/free : accept, reply
//   A result sits in the output register; the next one is computed once it
//   is taken, so a stalled receiver simply holds the sequencer.
//   Reset clears time to zero, frees every slot and clears the frame select.
module one_shot_timer_pool (
  input  logic          clk,
  input  logic          rst_n,
  ostp_req_if.sink      in_chan,
  ostp_rsp_if.source    out_chan,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);
  import ostp_pkg::*;

  // Sequencer and control state
  state_t                 state_r, state_nxt;
  logic                   pal_r;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [NUM_SLOTS-1:0]   busy_r, busy_nxt;
  logic [NUM_SLOTS-1:0]   due_r, due_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       fire_cnt_r, fire_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Request payload held for the duration of the request
  logic [DUR_W-1:0]       dur_r;
  logic signed [VAL_W-1:0] param_r;
  logic [CB_W-1:0]        cb_r;
  logic [IDX_W-1:0]       ins_idx_r;
  kind_t                  reply_kind_r, reply_kind_nxt;
  logic [SLOT_W-1:0]      reply_slot_r, reply_slot_nxt;

  // Slot storage; contents are meaningful only while the slot is busy
  logic [TIME_W-1:0]      dl_r  [NUM_SLOTS];
  logic signed [VAL_W-1:0] val_r [NUM_SLOTS];
  logic [CB_W-1:0]        cbk_r [NUM_SLOTS];
  logic                   slot_we;

  // Output register
  kind_t                  o_kind_r;
  logic [SLOT_W-1:0]      o_slot_r;
  logic signed [VAL_W-1:0] o_param_r;
  logic [CB_W-1:0]        o_cb_r;
  logic [TIME_W-1:0]      o_time_r;
  logic                   o_last_r;
  logic                   out_free, out_load;
  kind_t                  load_kind;
  logic [SLOT_W-1:0]      load_slot;
  logic signed [VAL_W-1:0] load_param;
  logic [CB_W-1:0]        load_cb;
  logic                   load_last;

  // Shared adder: a + b (saturating) or a - b (carry out = a >= b)
  logic [TIME_W-1:0]      unit_b;
  logic                   unit_sub;
  logic [TIME_W:0]        unit_full;
  logic [TIME_W-1:0]      unit_sat;
  logic                   unit_ge;

  // Slot selection
  logic                   in_fire;
  logic [IDX_W-1:0]       free_idx, fire_idx;
  logic                   any_free;
  logic [NUM_SLOTS-1:0]   due_scan, due_left;
  logic                   fire_last;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // Operand select for the shared unit: the time counter is always operand a
  always_comb begin
    unit_sub = 1'b0;
    unit_b   = dl_r[idx_r];
    unique case (state_r)
      ST_ADVANCE: unit_b = pal_r ? INC_PAL : INC_NTSC;
      ST_INSERT:  unit_b = TIME_W'(dur_r);
      ST_SCAN:    unit_sub = 1'b1;
      default:    unit_b = dl_r[idx_r];
    endcase
  end

  assign unit_full = {1'b0, now_r} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                   + (TIME_W+1)'(unit_sub);
  assign unit_sat  = unit_full[TIME_W] ? '1 : unit_full[TIME_W-1:0];
  assign unit_ge   = unit_full[TIME_W];

  // Highest free slot and highest due slot
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    fire_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!busy_r[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
      if (due_r[i]) begin
        fire_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    due_scan        = due_r;
    due_scan[idx_r] = busy_r[idx_r] && unit_ge;
    due_left           = due_r;
    due_left[fire_idx] = 1'b0;
  end

  // Final fire: nothing due below, or the per-tick result budget is spent
  assign fire_last = (due_left == '0) || (fire_cnt_r == CNT_W'(MAX_OUT - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_chan.opcode == OP_TICK) begin
            state_nxt = ST_ADVANCE;
          end else if (in_chan.opcode == OP_INSERT && any_free) begin
            state_nxt = ST_INSERT;
          end else begin
            state_nxt = ST_REPLY;
          end
        end
      end
      ST_ADVANCE: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (idx_r == '0) begin
          state_nxt = (due_scan != '0) ? ST_FIRE : ST_REPLY;
        end
      end
      ST_FIRE: begin
        if (out_free && fire_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INSERT: state_nxt = ST_REPLY;
      ST_REPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and datapath outputs
  always_comb begin
    in_chan.ready  = (state_r == ST_IDLE);
    now_nxt        = now_r;
    busy_nxt       = busy_r;
    due_nxt        = due_r;
    idx_nxt        = idx_r;
    fire_cnt_nxt   = fire_cnt_r;
    reply_kind_nxt = reply_kind_r;
    reply_slot_nxt = reply_slot_r;
    slot_we        = 1'b0;
    out_load       = 1'b0;
    load_kind      = reply_kind_r;
    load_slot      = reply_slot_r;
    load_param     = '0;
    load_cb        = '0;
    load_last      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          reply_kind_nxt = KIND_DONE;
          reply_slot_nxt = '0;
          unique case (in_chan.opcode)
            OP_TICK:   fire_cnt_nxt = '0;
            OP_INSERT: begin
              if (!any_free) begin
                reply_kind_nxt = KIND_FULL;
              end
            end
            OP_DELETE: begin
              // Drop an out-of-range index
              if (in_chan.slot < SLOT_W'(NUM_SLOTS)) begin
                busy_nxt[in_chan.slot[IDX_W-1:0]] = 1'b0;
              end
            end
            OP_FREE_ALL: busy_nxt = '0;
            default:     busy_nxt = busy_r;
          endcase
        end
      end
      ST_ADVANCE: begin
        now_nxt = unit_sat;
        idx_nxt = IDX_W'(NUM_SLOTS - 1);
        due_nxt = '0;
      end
      ST_SCAN: begin
        due_nxt = due_scan;
        if (idx_r != '0) begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_FIRE: begin
        load_kind  = KIND_FIRED;
        load_slot  = SLOT_W'(fire_idx);
        load_param = val_r[fire_idx];
        load_cb    = cbk_r[fire_idx];
        load_last  = fire_last;
        if (out_free) begin
          out_load           = 1'b1;
          busy_nxt[fire_idx] = 1'b0;
          due_nxt            = due_left;
          fire_cnt_nxt       = fire_cnt_r + 1'b1;
        end
      end
      ST_INSERT: begin
        slot_we             = 1'b1;
        busy_nxt[ins_idx_r] = 1'b1;
        reply_kind_nxt      = KIND_INSERTED;
        reply_slot_nxt      = SLOT_W'(ins_idx_r);
      end
      ST_REPLY: begin
        out_load = out_free;
      end
      default: out_load = 1'b0;
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pal_r        <= 1'b0;
      now_r        <= '0;
      busy_r       <= '0;
      due_r        <= '0;
      idx_r        <= '0;
      fire_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      reply_kind_r <= KIND_DONE;
      reply_slot_r <= '0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      busy_r       <= busy_nxt;
      due_r        <= due_nxt;
      idx_r        <= idx_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      reply_kind_r <= reply_kind_nxt;
      reply_slot_r <= reply_slot_nxt;
      if (cfg_we) begin
        pal_r <= cfg_wdata;
      end
    end
  end

  // Payload registers and slot storage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dur_r     <= in_chan.duration;
      param_r   <= in_chan.param;
      cb_r      <= in_chan.callback_id;
      ins_idx_r <= free_idx;
    end
    if (slot_we) begin
      dl_r[ins_idx_r]  <= unit_sat;
      val_r[ins_idx_r] <= param_r;
      cbk_r[ins_idx_r] <= cb_r;
    end
    if (out_load) begin
      o_kind_r  <= load_kind;
      o_slot_r  <= load_slot;
      o_param_r <= load_param;
      o_cb_r    <= load_cb;
      o_time_r  <= now_r;
      o_last_r  <= load_last;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.kind         = o_kind_r;
  assign out_chan.slot_out     = o_slot_r;
  assign out_chan.param_out    = o_param_r;
  assign out_chan.callback_out = o_cb_r;
  assign out_chan.last         = o_last_r;
  // Stamp time with the result: the next tick may advance the counter while it waits
  assign out_chan.current_time = o_time_r;

  // Checks
  a_fire_budget: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= CNT_W'(MAX_OUT))
    else $error("fire count exceeds result budget");

  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> now_r >= $past(now_r))
    else $error("time counter moved backward");

  a_fire_has_due: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIRE |-> due_r != '0)
    else $error("fire state with no due slot");

  a_fire_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIRE && out_load) |=> !busy_r[$past(fire_idx)])
    else $error("fired slot still armed");

  a_insert_arms: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INSERT |=> busy_r[$past(ins_idx_r)] && reply_kind_r == KIND_INSERTED)
    else $error("insert did not arm its slot");

endmodule

@@ bench/tb_one_shot_timer_pool.sv @@
// Self-checking testbench for one_shot_timer_pool: directed and random requests with a
// cycle-free predictor of the timer pool. Depends on ostp_pkg and the channels in ostp_if.sv.
module tb_one_shot_timer_pool;
  import ostp_pkg::*;

  // Tick increments, 1/1024 us: a 16.66 ms and a 20 ms frame, each divided by 256.
  localparam logic [47:0] TICK_NTSC = 48'd66640;
  localparam logic [47:0] TICK_PAL  = 48'd80000;
  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 2000;

  typedef struct {
    kind_t              kind;
    logic [1:0]         slot_id;
    logic signed [31:0] value;
    logic [1:0]         cbk;
    logic [47:0]        stamp;
    logic               is_last;
  } pool_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  ostp_req_if req_ch();
  ostp_rsp_if rsp_ch();

  one_shot_timer_pool DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted pool state: time counter, frame mode and one entry per slot.
  logic [47:0]        pool_now;
  logic               pal_sel;
  logic               slot_armed [NUM_SLOTS];
  logic [47:0]        slot_due   [NUM_SLOTS];
  logic signed [31:0] slot_param [NUM_SLOTS];
  logic [1:0]         slot_cb    [NUM_SLOTS];

  pool_rsp_t predicted_rsp[$];

  int  mismatches    = 0;
  int  requests_sent = 0;
  int  results_seen  = 0;
  int  fires_seen    = 0;
  int  full_seen     = 0;
  int  rx_hold       = 0;
  int  idle_cycles   = 0;
  // Set for a stretch of traffic in which neither side idles.
  bit  quiet_mode    = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Add with saturation at the top of the 48-bit time range.
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[48] ? '1 : sum[47:0];
  endfunction

  function automatic pool_rsp_t make_rsp(input kind_t kind, input logic [1:0] slot_id,
                                         input logic signed [31:0] value,
                                         input logic [1:0] cbk);
    pool_rsp_t r;
    r.kind    = kind;
    r.slot_id = slot_id;
    r.value   = value;
    r.cbk     = cbk;
    r.stamp   = pool_now;
    r.is_last = 1'b0;
    return r;
  endfunction

  // Apply one accepted request to the predicted pool and queue the results it causes.
  task automatic predict_pool(input op_t op, input logic [31:0] dur,
                              input logic signed [31:0] par, input logic [1:0] cb,
                              input logic [1:0] sl);
    pool_rsp_t batch[$];
    int i;
    int free_idx;
    batch    = {};
    free_idx = -1;
    case (op)
      OP_TICK: begin
        pool_now = sat_add48(pool_now, pal_sel ? TICK_PAL : TICK_NTSC);
        // Fire due slots from the highest index down, at most MAX_OUT per tick.
        for (i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (batch.size() < MAX_OUT && slot_armed[i] && pool_now >= slot_due[i]) begin
            slot_armed[i] = 1'b0;
            batch.push_back(make_rsp(KIND_FIRED, 2'(i), slot_param[i], slot_cb[i]));
          end
        end
        if (batch.size() == 0) batch.push_back(make_rsp(KIND_DONE, 2'd0, 32'sd0, 2'd0));
      end
      OP_INSERT: begin
        for (i = NUM_SLOTS - 1; i >= 0 && free_idx < 0; i--) begin
          if (!slot_armed[i]) free_idx = i;
        end
        if (free_idx >= 0) begin
          slot_due[free_idx]   = sat_add48(pool_now, {16'd0, dur});
          slot_param[free_idx] = par;
          slot_cb[free_idx]    = cb;
          slot_armed[free_idx] = 1'b1;
          batch.push_back(make_rsp(KIND_INSERTED, 2'(free_idx), 32'sd0, 2'd0));
        end else begin
          batch.push_back(make_rsp(KIND_FULL, 2'd0, 32'sd0, 2'd0));
        end
      end
      OP_DELETE: begin
        // Out-of-range indexes are ignored.
        if (sl < NUM_SLOTS) slot_armed[sl] = 1'b0;
        batch.push_back(make_rsp(KIND_DONE, 2'd0, 32'sd0, 2'd0));
      end
      default: begin
        for (i = 0; i < NUM_SLOTS; i++) slot_armed[i] = 1'b0;
        batch.push_back(make_rsp(KIND_DONE, 2'd0, 32'sd0, 2'd0));
      end
    endcase
    batch[batch.size() - 1].is_last = 1'b1;
    foreach (batch[k]) predicted_rsp.push_back(batch[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request and hold it until the block takes it. Return in the time step of
  // the handshake with valid still high, so a back-to-back request needs no second
  // assignment to valid in that step.
  task automatic send_request(input op_t op, input logic [31:0] dur,
                              input logic signed [31:0] par, input logic [1:0] cb,
                              input logic [1:0] sl);
    int gap;
    gap = quiet_mode ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.duration    <= dur;
    req_ch.param       <= par;
    req_ch.callback_id <= cb;
    req_ch.slot        <= sl;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    requests_sent++;
    predict_pool(op, dur, par, cb, sl);
  endtask

  // Drop valid right at the last handshake and hold until every result has come back.
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (predicted_rsp.size() != 0) @(posedge clk);
  endtask

  // Load the frame select once the block has gone idle.
  task automatic set_frame_mode(input logic pal);
    wait_drain();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= pal;
    @(posedge clk);
    cfg_we  <= 1'b0;
    pal_sel = pal;
  endtask

  // Receiver: accept by default, drop ready for random stretches unless in quiet mode.
  always @(posedge clk) begin : drive_ready
    if (rx_hold > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!quiet_mode && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Compare every taken result, field by field, with the oldest prediction.
  always @(posedge clk) begin : check_results
    pool_rsp_t want;
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      results_seen++;
      if (predicted_rsp.size() == 0) begin
        report_mismatch("result with none pending", 64'(rsp_ch.kind), 64'd0);
      end else begin
        want = predicted_rsp.pop_front();
        if (want.kind == KIND_FIRED) fires_seen++;
        if (want.kind == KIND_FULL) full_seen++;
        if (rsp_ch.kind !== want.kind)
          report_mismatch("kind", 64'(rsp_ch.kind), 64'(want.kind));
        if (rsp_ch.slot_out !== want.slot_id)
          report_mismatch("slot_out", 64'(rsp_ch.slot_out), 64'(want.slot_id));
        if (rsp_ch.param_out !== want.value)
          report_mismatch("param_out", 64'(unsigned'(rsp_ch.param_out)),
                          64'(unsigned'(want.value)));
        if (rsp_ch.callback_out !== want.cbk)
          report_mismatch("callback_out", 64'(rsp_ch.callback_out), 64'(want.cbk));
        if (rsp_ch.current_time !== want.stamp)
          report_mismatch("current_time", 64'(rsp_ch.current_time), 64'(want.stamp));
        if (rsp_ch.last !== want.is_last)
          report_mismatch("last", 64'(rsp_ch.last), 64'(want.is_last));
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Tick on an empty pool, delete of a free slot, delete of an out-of-range index,
  // free-all with nothing armed.
  task automatic test_idle_ops();
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
    send_request(OP_DELETE, 32'hFFFF_FFFF, -32'sd1, 2'd3, 2'd0);
    send_request(OP_DELETE, 32'd0, 32'sd0, 2'd0, 2'd3);
    send_request(OP_FREE_ALL, 32'd0, 32'sd0, 2'd0, 2'd0);
  endtask

  // Fill all slots with due timers and fire them in one tick, highest slot first;
  // cover param extremes, every callback id including none, and a deadline equal to
  // the tick time. Then a deadline one unit past the tick, which waits one more tick.
  task automatic test_fire_order();
    send_request(OP_INSERT, 32'd0, 32'sh7FFF_FFFF, 2'd0, 2'd0);
    send_request(OP_INSERT, 32'd0, 32'sh8000_0000, 2'd3, 2'd0);
    send_request(OP_INSERT, 32'd66640, -32'sd1, 2'd1, 2'd0);
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
    send_request(OP_INSERT, 32'd66641, 32'sd0, 2'd2, 2'd0);
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
  endtask

  // Fill the pool with far deadlines, hit the full case, free one slot and reuse it.
  task automatic test_pool_full();
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'sh5555_5555, 2'd1, 2'd0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'shAAAA_AAAA, 2'd2, 2'd0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'sd1, 2'd3, 2'd0);
    send_request(OP_INSERT, 32'd0, 32'sd7, 2'd1, 2'd0);
    send_request(OP_DELETE, 32'd0, 32'sd0, 2'd0, 2'd1);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'sd9, 2'd2, 2'd0);
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
    send_request(OP_FREE_ALL, 32'd0, 32'sd0, 2'd0, 2'd0);
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
  endtask

  // The 20 ms increment: a deadline exactly one tick away fires, one unit more waits.
  task automatic test_frame_modes();
    set_frame_mode(1'b1);
    send_request(OP_INSERT, 32'd80000, 32'sd123, 2'd2, 2'd0);
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
    send_request(OP_INSERT, 32'd80001, -32'sd123, 2'd1, 2'd0);
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
    send_request(OP_TICK, 32'd0, 32'sd0, 2'd0, 2'd0);
    set_frame_mode(1'b0);
  endtask

  // Random traffic: mostly ticks and short inserts so timers keep firing, some far
  // deadlines that only delete or free-all clears, and junk in the unused fields.
  task automatic test_random_traffic(input int n_items);
    int          r;
    op_t         op;
    logic [31:0] dur;
    logic [31:0] par;
    for (int n = 0; n < n_items; n++) begin
      r   = $urandom_range(0, 99);
      dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 240000);
      par = $urandom;
      if (r < 45) op = OP_TICK;
      else if (r < 80) op = OP_INSERT;
      else if (r < 92) op = OP_DELETE;
      else op = OP_FREE_ALL;
      send_request(op, dur, par, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      // Now and then hold the sender until the pool has answered everything.
      if ($urandom_range(0, 39) == 0) wait_drain();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_TICK;
    req_ch.duration    = '0;
    req_ch.param       = '0;
    req_ch.callback_id = '0;
    req_ch.slot        = '0;
    pool_now           = '0;
    pal_sel            = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_armed[i] = 1'b0;
      slot_due[i]   = '0;
      slot_param[i] = '0;
      slot_cb[i]    = '0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_ops();
    test_fire_order();
    test_pool_full();
    test_frame_modes();

    // Random segments, each under its own frame mode; the third runs with no idling.
    for (int seg = 0; seg < 5; seg++) begin
      set_frame_mode((seg == 1 || seg == 3) ? 1'b1 : 1'($urandom_range(0, 1)));
      quiet_mode = (seg == 2);
      test_random_traffic(60);
      quiet_mode = 1'b0;
    end

    wait_drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d requests and %0d results in both frame modes", requests_sent,
             results_seen);
    $display("  including %0d timer fires and %0d pool-full replies", fires_seen, full_seen);
    if (mismatches == 0 && predicted_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ostp_pkg.sv
hw/rtl/ostp_if.sv
hw/rtl/one_shot_timer_pool.sv
bench/tb_one_shot_timer_pool.sv
